>>> design/nblc_pkg.sv
// Shared types, constants and helpers for the naive Bayes log-odds classifier.
`timescale 1ns / 1ps

package nblc_pkg;

  localparam int MAX_FEATURES = 64;
  localparam int MAX_VALUES   = 16;

  localparam int FEAT_AW   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int VAL_AW    = $clog2(MAX_VALUES);
  localparam int KIND_W    = $clog2(MAX_VALUES + 1);
  localparam int TBL_DEPTH = MAX_FEATURES * MAX_VALUES;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);

  localparam int WORD_W = 32;
  localparam int FRAC_W = 16;
  localparam int PROD_W = 2 * WORD_W;
  localparam int ACC_W  = 48;
  localparam int SUM_W  = ACC_W + 1;

  // Feature kind codes; anything above KIND_CONT is a discrete value count.
  localparam logic [KIND_W-1:0] KIND_IGNORED = '0;
  localparam logic [KIND_W-1:0] KIND_CONT    = KIND_W'(1);

  typedef enum logic {
    OP_LOAD     = 1'b0,
    OP_CLASSIFY = 1'b1
  } nblc_op_t;

  typedef struct packed {
    nblc_op_t            operation;
    logic [5:0]          feature_index;
    logic [3:0]          value_index;
    logic [4:0]          value_count;
    logic signed [31:0]  weight;
    logic signed [31:0]  feature_value;
    logic                last_feature;
  } nblc_in_t;

  typedef struct packed {
    logic                class_label;
    logic signed [47:0]  logit;
    logic                index_error;
  } nblc_out_t;

  // One scored sample on its way to the accumulator; prod is Q32.32.
  typedef struct packed {
    logic                     vld;
    logic                     last;
    logic                     err;
    logic signed [PROD_W-1:0] prod;
  } nblc_term_t;

  function automatic logic [TBL_AW-1:0] tbl_addr(input logic [FEAT_AW-1:0] f,
                                                 input logic [VAL_AW-1:0]  v);
    return TBL_AW'(TBL_AW'(f) * TBL_AW'(MAX_VALUES) + TBL_AW'(v));
  endfunction

endpackage

>>> design/naive_bayes_log_odds_classifier.sv
// Top level of the binary naive Bayes log-odds classifier.
`timescale 1ns / 1ps

// Channel   Ports                                   Carries
// in        in_valid / in_ready / in_req            load or classify request
// out       out_valid / out_ready / out_result      class, log-odds, index error
// cfg       cfg_wr_en / cfg_wr_data                 bias register write
//
// One request per cycle sustained while results are taken; a last sample's
// result is loaded into the output register after the memory read at
// acceptance, the product register, then the accumulate.
// The rate is set by the accumulator register, one saturating add per cycle unless a last term waits on a result.
// Synchronous active-low reset clears control state, feature kinds and bias;
// the weight table is not cleared and must be loaded before use.
// While a result waits, samples ahead still accumulate; the next last sample
// waits in the product stage and the input backs up behind it.
module naive_bayes_log_odds_classifier (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  nblc_pkg::nblc_in_t  in_req,
  output logic                out_valid,
  input  logic                out_ready,
  output nblc_pkg::nblc_out_t out_result,
  input  logic                cfg_wr_en,
  input  logic signed [31:0]  cfg_wr_data
);
  import nblc_pkg::*;

  // Scored sample handed from the lookup/product stages to the accumulator.
  nblc_term_t term;
  logic       term_take;

  // Lookup side: loads write the kind and weight memories at acceptance, so
  // a classify request in the very next cycle already reads the new data.
  nblc_lookup u_lookup (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .term_o    (term),
    .term_take (term_take)
  );

  // Accumulator side: opens an object at the bias, adds each term with
  // 48-bit saturation and posts the result on the last sample.
  nblc_accum u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .term_i      (term),
    .term_take   (term_take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_result  (out_result)
  );

endmodule

>>> design/nblc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module nblc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/nblc_lookup.sv
// Weight and kind memories, table lookup and product stage.
`timescale 1ns / 1ps

module nblc_lookup (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  nblc_pkg::nblc_in_t   in_req,
  output nblc_pkg::nblc_term_t term_o,
  input  logic                 term_take
);
  import nblc_pkg::*;

  logic                       accept, is_load, is_cls, f_ok, vi_ok;
  logic [FEAT_AW-1:0]         f_addr;
  logic [VAL_AW-1:0]          vi_addr, c_addr;
  logic [KIND_W-1:0]          kind_wr, kind_rd, kind;
  logic [WORD_W-1:0]          cont_rd, disc_rd;
  logic [MAX_FEATURES-1:0]    kvld_r;

  logic                       s1_vld_r, s1_last_r, s1_fok_r;
  logic [FEAT_AW-1:0]         s1_f_r;
  logic signed [WORD_W-1:0]   s1_x_r;
  logic                       s1_go, s1_free, s2_free;
  logic                       is_cont, is_disc, c_ok;
  logic signed [PROD_W-1:0]   mul, prod_nxt;

  logic                       t_vld_r, t_last_r, t_err_r;
  logic signed [PROD_W-1:0]   t_prod_r;

  assign s2_free  = !t_vld_r || term_take;
  assign s1_go    = s1_vld_r && s2_free;
  assign s1_free  = !s1_vld_r || s1_go;
  assign in_ready = s1_free;
  assign accept   = in_valid && s1_free;
  assign is_load  = accept && (in_req.operation == OP_LOAD);
  assign is_cls   = accept && (in_req.operation == OP_CLASSIFY);

  assign f_ok    = 32'(in_req.feature_index) < MAX_FEATURES;
  assign f_addr  = FEAT_AW'(in_req.feature_index);
  assign vi_ok   = 32'(in_req.value_index) < MAX_VALUES;
  assign vi_addr = VAL_AW'(in_req.value_index);
  assign c_addr  = in_req.feature_value[FRAC_W +: VAL_AW];
  assign kind_wr = (32'(in_req.value_count) > MAX_VALUES) ? KIND_W'(MAX_VALUES)
                                                           : KIND_W'(in_req.value_count);

  nblc_ram #(.WIDTH(KIND_W), .DEPTH(MAX_FEATURES)) u_kind_ram (
    .clk   (clk),
    .we    (is_load && f_ok),
    .waddr (f_addr),
    .wdata (kind_wr),
    .re    (is_cls),
    .raddr (f_addr),
    .rdata (kind_rd)
  );

  // Slot 0 copy, so a continuous weight and a discrete entry read together.
  nblc_ram #(.WIDTH(WORD_W), .DEPTH(MAX_FEATURES)) u_cont_ram (
    .clk   (clk),
    .we    (is_load && f_ok && vi_ok && (vi_addr == '0)),
    .waddr (f_addr),
    .wdata (in_req.weight),
    .re    (is_cls),
    .raddr (f_addr),
    .rdata (cont_rd)
  );

  nblc_ram #(.WIDTH(WORD_W), .DEPTH(TBL_DEPTH)) u_disc_ram (
    .clk   (clk),
    .we    (is_load && f_ok && vi_ok),
    .waddr (tbl_addr(f_addr, vi_addr)),
    .wdata (in_req.weight),
    .re    (is_cls),
    .raddr (tbl_addr(f_addr, c_addr)),
    .rdata (disc_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kvld_r <= '0;
    end else if (is_load && f_ok) begin
      kvld_r[f_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_free) begin
      s1_vld_r <= is_cls;
    end
  end

  always_ff @(posedge clk) begin
    if (is_cls) begin
      s1_last_r <= in_req.last_feature;
      s1_fok_r  <= f_ok;
      s1_f_r    <= f_addr;
      s1_x_r    <= in_req.feature_value;
    end
  end

  always_comb begin
    kind    = kvld_r[s1_f_r] ? kind_rd : KIND_IGNORED;
    is_cont = s1_fok_r && (kind == KIND_CONT);
    is_disc = s1_fok_r && (kind > KIND_CONT);
    c_ok    = !s1_x_r[WORD_W-1] &&
              ({1'b0, s1_x_r[WORD_W-2:FRAC_W]} < (WORD_W-FRAC_W)'(kind));
    mul     = PROD_W'(signed'(cont_rd)) * PROD_W'(s1_x_r);
    if (is_cont) begin
      prod_nxt = mul;
    end else if (is_disc && c_ok) begin
      prod_nxt = {{(PROD_W-WORD_W-FRAC_W){disc_rd[WORD_W-1]}}, disc_rd, {FRAC_W{1'b0}}};
    end else begin
      prod_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_vld_r <= 1'b0;
    end else if (s2_free) begin
      t_vld_r <= s1_go;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      t_last_r <= s1_last_r;
      t_err_r  <= is_disc && !c_ok;
      t_prod_r <= prod_nxt;
    end
  end

  assign term_o = '{vld: t_vld_r, last: t_last_r, err: t_err_r, prod: t_prod_r};

`ifndef NO_ASSERTIONS
  a_term_hold: assert property (@(posedge clk) disable iff (!rst_n)
    t_vld_r && !term_take |=> t_vld_r && $stable(t_prod_r) && $stable(t_last_r))
    else $error("product stage lost or changed a stalled term");

  a_kind_mark: assert property (@(posedge clk) disable iff (!rst_n)
    is_load && f_ok |=> kvld_r[$past(f_addr)])
    else $error("kind valid bit not set after a load");
`endif

endmodule

>>> design/nblc_accum.sv
// Bias register, saturating log-odds accumulator and result register.
`timescale 1ns / 1ps

module nblc_accum (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic signed [31:0]   cfg_wr_data,
  input  nblc_pkg::nblc_term_t term_i,
  output logic                 term_take,
  output logic                 out_valid,
  input  logic                 out_ready,
  output nblc_pkg::nblc_out_t  out_result
);
  import nblc_pkg::*;

  logic signed [WORD_W-1:0] bias_r;
  logic signed [ACC_W-1:0]  acc_r, base, term_val, acc_sat;
  logic signed [SUM_W-1:0]  sum;
  logic                     open_r, err_r, err_nxt, out_free, out_vld_r;
  nblc_out_t                out_r;

  assign out_free  = !out_vld_r || out_ready;
  assign term_take = term_i.vld && (!term_i.last || out_free);

  always_comb begin
    base     = open_r ? acc_r : ACC_W'(bias_r);
    term_val = term_i.prod[PROD_W-1:FRAC_W];
    sum      = SUM_W'(base) + SUM_W'(term_val);
    if (sum[SUM_W-1] != sum[SUM_W-2]) begin
      acc_sat = sum[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_sat = sum[ACC_W-1:0];
    end
    err_nxt = (open_r && err_r) || term_i.err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r <= '0;
    end else if (cfg_wr_en) begin
      bias_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      open_r <= 1'b0;
      err_r  <= 1'b0;
    end else if (term_take) begin
      acc_r  <= acc_sat;
      open_r <= !term_i.last;
      err_r  <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= term_take && term_i.last;
    end
  end

  always_ff @(posedge clk) begin
    if (term_take && term_i.last) begin
      out_r.class_label <= !acc_sat[ACC_W-1] && (acc_sat != '0);
      out_r.logit       <= acc_sat;
      out_r.index_error <= err_nxt;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_result = out_r;

`ifndef NO_ASSERTIONS
  a_class_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_r.class_label == (out_r.logit > 0))
    else $error("class label disagrees with log-odds sign");

  a_close_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(open_r) |-> $past(term_take && term_i.last))
    else $error("object closed without a last sample");

  a_result_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(term_take && term_i.last))
    else $error("result appeared without a last sample");
`endif

endmodule
